// ----- src/vnr_pkg.sv -----
`default_nettype none

package vnr_pkg;

    // Widths fixed by the field definitions
    localparam int VAL_W       = 31;
    localparam int OUT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int SAMPLE_BITS_DEFAULT = 10;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd2;

    // Reset values
    localparam logic [VAL_W-1:0] LOW_RESET  = 31'd0;
    localparam logic [VAL_W-1:0] HIGH_RESET = 31'd256;

    // First bit weight of each fixed word size
    localparam logic [VAL_W-1:0] PLACE_BYTE   = 31'h0000_0080;
    localparam logic [VAL_W-1:0] PLACE_WORD15 = 31'h0000_4000;
    localparam logic [VAL_W-1:0] PLACE_WORD31 = 31'h4000_0000;

    typedef enum logic [1:0] {
        MODE_BYTE   = 2'd0,
        MODE_WORD15 = 2'd1,
        MODE_WORD31 = 2'd2,
        MODE_RANGE  = 2'd3
    } mode_t;

    // Settings handed from the register block to the datapath
    typedef struct packed {
        mode_t             mode;
        logic [VAL_W-1:0]  low;        // signed lower bound
        logic [OUT_W-1:0]  diff_m1;    // high - low - 1, signed
        logic              degenerate; // range holds at most one value
        logic              restart;    // register written: drop partial value
    } cfg_t;

endpackage

`default_nettype wire

// ----- src/von_neumann_random_ranger.sv -----
`default_nettype none

// True-random word source fed by converter noise. Only bit 0 of each sample
// is used. Two cascaded von Neumann stages whiten it, so each whitened bit
// takes at least four samples, and sixteen on average for unbiased noise.
// Whitened bits are shifted in MSB first to give an 8-, 15- or 31-bit word,
// or a value in [range_low, range_high) that is rebuilt whenever it reaches
// the range width. One sample is taken every clock while results are being
// collected. A sample is first held in the input register, then processed
// into the result register. While a finished value waits there untaken,
// the next sample is held in the input register and the input stalls
// until the value is transferred out. A write to any register restarts the
// value being built. In range mode with a range of one value or none, every
// sample returns range_low at once.
module von_neumann_random_ranger #(
    parameter int SAMPLE_BITS = vnr_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // sample channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [SAMPLE_BITS-1:0]        adc_sample,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [vnr_pkg::OUT_W-1:0]   random_value,
    // register writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [vnr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vnr_pkg::VAL_W-1:0]     cfg_data
);
    import vnr_pkg::*;

    cfg_t             cfg;
    logic             in_valid_reg;
    logic             in_bit_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_value_reg;
    logic             fire;
    logic             direct;
    logic             white_valid;
    logic             white_bit;
    logic             build_valid;
    logic [OUT_W-1:0] build_value;
    logic             res_valid;
    logic [OUT_W-1:0] res_value;

    vnr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Process the held sample when the result register can take a value
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;
    assign direct   = (cfg.mode == MODE_RANGE) && cfg.degenerate;

    vnr_whiten u_whiten (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (fire && !direct),
        .raw_bit     (in_bit_reg),
        .white_valid (white_valid),
        .white_bit   (white_bit)
    );

    vnr_build u_build (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (fire && !direct),
        .white_valid (white_valid),
        .white_bit   (white_bit),
        .cfg         (cfg),
        .res_valid   (build_valid),
        .res_value   (build_value)
    );

    // Empty or single-value range returns the lower bound straight away
    assign res_valid = fire && (direct || build_valid);
    assign res_value = direct ? {cfg.low[VAL_W-1], cfg.low} : build_value;

    // Input register: only the noise bit is kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_bit_reg <= adc_sample[0];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_value_reg <= res_value;
        end
    end

    assign out_valid    = out_valid_reg;
    assign random_value = out_value_reg;

endmodule

`default_nettype wire

// ----- src/vnr_cfg.sv -----
`default_nettype none

module vnr_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [vnr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vnr_pkg::VAL_W-1:0]     cfg_data,
    output vnr_pkg::cfg_t                      cfg
);
    import vnr_pkg::*;

    mode_t             mode_reg;
    logic [VAL_W-1:0]  low_reg;
    logic [VAL_W-1:0]  high_reg;
    logic [OUT_W-1:0]  diff_m1_reg;
    logic [VAL_W-1:0]  low_next;
    logic [VAL_W-1:0]  high_next;
    logic [OUT_W-1:0]  diff_m1_next;
    logic              wr;
    logic              hit;

    assign cfg_ready = 1'b1;
    assign wr  = cfg_valid && cfg_ready;
    assign hit = wr && (cfg_index == REG_MODE || cfg_index == REG_LOW
                        || cfg_index == REG_HIGH);

    // Bounds as they stand after this transfer
    always_comb
    begin
        low_next  = (wr && cfg_index == REG_LOW)  ? cfg_data : low_reg;
        high_next = (wr && cfg_index == REG_HIGH) ? cfg_data : high_reg;
        // high - low - 1 == high + ~low, both sign extended
        diff_m1_next = {high_next[VAL_W-1], high_next} + ~{low_next[VAL_W-1], low_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_BYTE;
            low_reg     <= LOW_RESET;
            high_reg    <= HIGH_RESET;
            diff_m1_reg <= {1'b0, HIGH_RESET} - {1'b0, LOW_RESET} - OUT_W'(1);
        end
        else if (wr)
        begin
            if (cfg_index == REG_MODE)
            begin
                mode_reg <= mode_t'(cfg_data[1:0]);
            end
            low_reg     <= low_next;
            high_reg    <= high_next;
            diff_m1_reg <= diff_m1_next;
        end
    end

    // diff <= 1 means diff - 1 is zero or negative
    assign cfg.mode       = mode_reg;
    assign cfg.low        = low_reg;
    assign cfg.diff_m1    = diff_m1_reg;
    assign cfg.degenerate = diff_m1_reg[OUT_W-1] || (diff_m1_reg == '0);
    assign cfg.restart    = hit;

endmodule

`default_nettype wire

// ----- src/vnr_whiten.sv -----
`default_nettype none

module vnr_whiten (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic raw_bit,
    output logic      white_valid,
    output logic      white_bit
);
    import vnr_pkg::*;

    logic raw_first_reg;
    logic raw_have_reg;
    logic white_first_reg;
    logic white_have_reg;
    logic b1_valid;

    // First stage yields a bit on an unequal pair; the second bit is the output
    assign b1_valid    = raw_have_reg && (raw_first_reg != raw_bit);
    assign white_valid = b1_valid && white_have_reg && (white_first_reg != raw_bit);
    assign white_bit   = raw_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_first_reg   <= 1'b0;
            raw_have_reg    <= 1'b0;
            white_first_reg <= 1'b0;
            white_have_reg  <= 1'b0;
        end
        else if (en)
        begin
            if (!raw_have_reg)
            begin
                raw_first_reg <= raw_bit;
            end
            raw_have_reg <= !raw_have_reg;

            // second stage only sees bits the first one passes
            if (b1_valid)
            begin
                if (!white_have_reg)
                begin
                    white_first_reg <= raw_bit;
                end
                white_have_reg <= !white_have_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/vnr_build.sv -----
`default_nettype none

module vnr_build (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      white_valid,
    input  wire logic                      white_bit,
    input  wire vnr_pkg::cfg_t             cfg,
    output logic                           res_valid,
    output logic [vnr_pkg::OUT_W-1:0]      res_value
);
    import vnr_pkg::*;

    logic [VAL_W-1:0] acc_reg;
    logic [VAL_W-1:0] place_reg;
    logic [VAL_W-1:0] acc_next;
    logic [VAL_W-1:0] place_next;
    logic [VAL_W-1:0] span;
    logic [VAL_W-1:0] s1, s2, s4, s8, s16;
    logic [VAL_W-1:0] range_top;
    logic [VAL_W-1:0] start_place;
    logic [VAL_W-1:0] place_cur;
    logic [VAL_W-1:0] acc_base;
    logic [VAL_W-1:0] acc_or;
    logic [VAL_W-1:0] place_sh;
    logic [OUT_W-1:0] ranged;
    logic             too_big;

    // Top set bit of diff - 1: smear right, then keep the leading one
    assign span  = cfg.diff_m1[VAL_W-1:0];
    assign s1    = span | (span >> 1);
    assign s2    = s1 | (s1 >> 2);
    assign s4    = s2 | (s2 >> 4);
    assign s8    = s4 | (s4 >> 8);
    assign s16   = s8 | (s8 >> 16);
    assign range_top = s16 & ~(s16 >> 1);

    always_comb
    begin
        case (cfg.mode)
            MODE_BYTE:   start_place = PLACE_BYTE;
            MODE_WORD15: start_place = PLACE_WORD15;
            MODE_WORD31: start_place = PLACE_WORD31;
            MODE_RANGE:  start_place = range_top;
            default:     start_place = PLACE_BYTE;
        endcase
    end

    // Shift the whitened bit in at the current weight
    assign place_cur = (place_reg == '0) ? start_place : place_reg;
    assign acc_base  = (place_reg == '0) ? '0 : acc_reg;
    assign acc_or    = acc_base | (white_bit ? place_cur : '0);
    assign place_sh  = place_cur >> 1;
    assign too_big   = (cfg.mode == MODE_RANGE) && (acc_or > span);
    assign ranged    = {1'b0, acc_or} + {cfg.low[VAL_W-1], cfg.low};

    always_comb
    begin
        acc_next   = acc_reg;
        place_next = place_reg;
        res_valid  = 1'b0;
        res_value  = {1'b0, acc_or};
        if (en && white_valid)
        begin
            if (too_big)
            begin
                // out of range: start over
                acc_next   = '0;
                place_next = '0;
            end
            else if (place_sh == '0)
            begin
                res_valid  = 1'b1;
                res_value  = (cfg.mode == MODE_RANGE) ? ranged : {1'b0, acc_or};
                acc_next   = '0;
                place_next = '0;
            end
            else
            begin
                acc_next   = acc_or;
                place_next = place_sh;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            place_reg <= '0;
        end
        else if (cfg.restart)
        begin
            acc_reg   <= '0;
            place_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            place_reg <= place_next;
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_von_neumann_random_ranger.sv -----
`timescale 1ns / 1ps

module tb_von_neumann_random_ranger;
    import vnr_pkg::*;

    localparam int SAMPLE_W     = SAMPLE_BITS_DEFAULT;
    localparam int HOLD_CYCLES  = 200;
    localparam int ITEM_TARGET  = 1250;
    localparam int VALUE_TARGET = 60;
    localparam int SETTLE_TICKS = 4;
    localparam logic [VAL_W-1:0] VAL_MIN = 31'h4000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX = 31'h3FFF_FFFF;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [SAMPLE_W-1:0]     adc_sample = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [OUT_W-1:0] random_value;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_MODE;
    logic [VAL_W-1:0]        cfg_data = '0;

    von_neumann_random_ranger #(
        .SAMPLE_BITS(SAMPLE_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .adc_sample   (adc_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .random_value (random_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // shadow of the register settings
    mode_t            set_mode = MODE_BYTE;
    logic [VAL_W-1:0] set_low  = LOW_RESET;
    logic [VAL_W-1:0] set_high = HIGH_RESET;

    // shadow of the whitening stages and the value under construction
    bit               raw_first   = 1'b0;
    bit               raw_have    = 1'b0;
    bit               white_first = 1'b0;
    bit               white_have  = 1'b0;
    logic [VAL_W-1:0] acc_bits    = '0;
    logic [VAL_W-1:0] next_weight = '0;

    logic [SAMPLE_W-1:0] sample_backlog[$];
    logic [OUT_W-1:0]    random_words_due[$];

    int  send_gap_pct   = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 1'b0;
    bit  hold_off       = 1'b0;
    int  samples_queued = 0;
    int  samples_taken  = 0;
    int  values_built   = 0;
    int  values_checked = 0;
    int  settings_seen  = 0;
    int  fault_count    = 0;

    // one von Neumann stage: returns 1 when a bit comes out
    function automatic bit whiten(inout bit first, inout bit have, input bit b, output bit o);
        o = b;
        if (!have)
        begin
            first = b;
            have  = 1'b1;
            return 1'b0;
        end
        have = 1'b0;
        return first != b;
    endfunction

    function automatic longint range_width();
        longint hi_v;
        longint lo_v;
        hi_v = longint'($signed(set_high));
        lo_v = longint'($signed(set_low));
        return hi_v - lo_v;
    endfunction

    // works out what one accepted sample makes the block emit
    function automatic void build_from_sample(input logic [SAMPLE_W-1:0] s);
        longint           lo_v;
        longint           width;
        longint           sum;
        logic [VAL_W-1:0] span;
        logic [VAL_W-1:0] span_m1;
        bit               raw_bit;
        bit               white_bit;
        lo_v  = longint'($signed(set_low));
        width = range_width();
        // empty or single-value range: low comes straight back
        if (set_mode == MODE_RANGE && width <= 1)
        begin
            random_words_due.push_back(lo_v[OUT_W-1:0]);
            values_built++;
            return;
        end
        if (!whiten(raw_first, raw_have, s[0], raw_bit))
            return;
        if (!whiten(white_first, white_have, raw_bit, white_bit))
            return;

        if (set_mode == MODE_RANGE)
        begin
            span = width[VAL_W-1:0];
            if (next_weight == '0)
            begin
                span_m1 = span - 1'b1;
                for (int k = VAL_W - 1; k >= 0; k--)
                    if (next_weight == '0 && span_m1[k])
                        next_weight[k] = 1'b1;
                acc_bits = '0;
            end
            if (white_bit)
                acc_bits |= next_weight;
            // out of range: throw away and start over
            if (acc_bits >= span)
            begin
                acc_bits    = '0;
                next_weight = '0;
                return;
            end
            next_weight >>= 1;
            if (next_weight == '0)
            begin
                sum = lo_v + longint'(acc_bits);
                random_words_due.push_back(sum[OUT_W-1:0]);
                values_built++;
                acc_bits = '0;
            end
            return;
        end

        // fixed word sizes
        if (next_weight == '0)
        begin
            case (set_mode)
                MODE_BYTE:   next_weight = PLACE_BYTE;
                MODE_WORD15: next_weight = PLACE_WORD15;
                default:     next_weight = PLACE_WORD31;
            endcase
            acc_bits = '0;
        end
        if (white_bit)
            acc_bits |= next_weight;
        next_weight >>= 1;
        if (next_weight == '0)
        begin
            random_words_due.push_back({1'b0, acc_bits});
            values_built++;
            acc_bits = '0;
        end
    endfunction

    // clock
    initial
    begin : clock_gen
        forever #5 clk = ~clk;
    end

    // sample driver
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (in_valid)
            begin
                build_from_sample(adc_sample);
                samples_taken++;
            end
            if (sample_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                in_valid   <= 1'b1;
                adc_sample <= sample_backlog.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and receiver pacing
    always @(posedge clk)
    begin : value_check
        logic [OUT_W-1:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                values_checked++;
                if (random_words_due.size() == 0)
                begin
                    $display("%0t: random_value expected none, got %0d", $time, random_value);
                    fault_count++;
                end
                else
                begin
                    want = random_words_due.pop_front();
                    if (random_value !== want)
                    begin
                        $display("%0t: random_value expected %0d, got %0d",
                                 $time, $signed(want), random_value);
                        fault_count++;
                    end
                end
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, once
    initial
    begin : receiver_hold
        wait (hold_req);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    // run limit
    initial
    begin : watchdog
        #5_000_000;
        $display("[von_neumann_random_ranger] ERROR");
        $finish;
    end

    function automatic void queue_raw(input logic [SAMPLE_W-1:0] s);
        sample_backlog.push_back(s);
        samples_queued++;
    endfunction

    function automatic void queue_sample(input bit lsb);
        logic [SAMPLE_W-1:0] s;
        s    = SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
        s[0] = lsb;
        queue_raw(s);
    endfunction

    // four samples that give exactly one white bit from aligned stages
    function automatic void queue_white_bit(input bit b);
        queue_sample(b);
        queue_sample(!b);
        queue_sample(!b);
        queue_sample(b);
    endfunction

    // mostly clean white bits, some dropped pairs, the odd stray sample
    function automatic void queue_chunk();
        int pick;
        bit b;
        pick = $urandom_range(99);
        b    = 1'($urandom_range(1));
        if (pick < 85)
            queue_white_bit(b);
        else if (pick < 92)
        begin
            queue_sample(b);
            queue_sample(b);
        end
        else if (pick < 98)
        begin
            queue_sample(!b);
            queue_sample(b);
            queue_sample(!b);
            queue_sample(b);
        end
        else
            queue_sample(b);
    endfunction

    // empty both whitening stages without letting a bit through
    function automatic void realign_stages();
        if (raw_have)
            queue_sample(raw_first);
        if (white_have)
        begin
            queue_sample(!white_first);
            queue_sample(white_first);
        end
    endfunction

    task automatic set_pacing(input int phase);
        case (phase % 4)
            0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_gap_pct = 84; recv_stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  recv_stall_pct = 84; end
            default: begin send_gap_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        // shadow follows the transfer; a real register restarts the value
        if (idx == REG_MODE)
            set_mode = mode_t'(data[1:0]);
        else if (idx == REG_LOW)
            set_low = data;
        else if (idx == REG_HIGH)
            set_high = data;
        if (idx != REG_NONE)
        begin
            acc_bits    = '0;
            next_weight = '0;
        end
    endtask

    // wait for every sample and value to be through, plus the pipeline
    task automatic wait_idle();
        do @(negedge clk);
        while (sample_backlog.size() != 0 || in_valid || random_words_due.size() != 0);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    // choose and write a new setting, or keep the old one running
    task automatic pick_setting();
        int               pick;
        int               lo;
        int               hi;
        logic [VAL_W-1:0] mode_word;
        logic [VAL_W-1:0] junk;
        pick      = $urandom_range(99);
        mode_word = VAL_W'($urandom);
        junk      = VAL_W'($urandom);
        if ($urandom_range(3) == 0)
            write_register(REG_NONE, junk);
        if (pick < 15)
            return;
        settings_seen++;
        if (pick < 32)
            mode_word[1:0] = MODE_BYTE;
        else if (pick < 42)
            mode_word[1:0] = MODE_WORD15;
        else if (pick < 47)
            mode_word[1:0] = MODE_WORD31;
        if (pick < 47)
        begin
            write_register(REG_MODE, mode_word);
            return;
        end

        mode_word[1:0] = MODE_RANGE;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            lo = $urandom_range(2000) - 1000;
            hi = lo + $urandom_range(2, 40);
        end
        else if (pick < 35)
        begin
            lo = -(1 << 30);
            hi = lo + $urandom_range(2, 40);
        end
        else if (pick < 42)
        begin
            hi = (1 << 30) - 1;
            lo = hi - $urandom_range(2, 40);
        end
        else if (pick < 60)
        begin
            // power-of-two width: never rejected
            lo = $urandom_range(4000) - 2000;
            hi = lo + (1 << $urandom_range(1, 12));
        end
        else if (pick < 66)
        begin
            lo = -(1 << 30);
            hi = (1 << 30) - 1;
        end
        else if (pick < 88)
        begin
            // empty or single-value ranges
            lo = $urandom_range(2000) - 1000;
            case ($urandom_range(3))
                0:       hi = lo;
                1:       hi = lo + 1;
                2:       hi = lo - $urandom_range(1, 50);
                default: begin lo = (1 << 30) - 1; hi = -(1 << 30); end
            endcase
        end
        else
        begin
            lo = $urandom;
            hi = $urandom;
        end
        if ($urandom_range(1))
        begin
            write_register(REG_LOW, lo[VAL_W-1:0]);
            write_register(REG_HIGH, hi[VAL_W-1:0]);
            write_register(REG_MODE, mode_word);
        end
        else
        begin
            write_register(REG_MODE, mode_word);
            write_register(REG_HIGH, hi[VAL_W-1:0]);
            write_register(REG_LOW, lo[VAL_W-1:0]);
        end
    endtask

    // one batch of samples under the current setting
    task automatic run_batch(input int phase);
        int  target;
        bit  degenerate;
        @(negedge clk);
        set_pacing(phase);
        degenerate = set_mode == MODE_RANGE && range_width() <= 1;
        target     = samples_queued + (degenerate ? $urandom_range(20, 40)
                                                  : $urandom_range(50, 110));
        if (!degenerate)
            realign_stages();
        while (samples_queued < target)
            queue_chunk();
        wait_idle();
    endtask

    // stimulus
    initial
    begin : stimulus
        int phase;
        phase = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting (bytes): a white one then a white zero, sample extremes
        @(negedge clk);
        set_pacing(3);
        queue_raw(10'h3FF);
        queue_raw(10'h000);
        queue_raw(10'h000);
        queue_raw(10'h3FF);
        queue_raw(10'h2AA);
        queue_raw(10'h155);
        queue_raw(10'h155);
        queue_raw(10'h2AA);
        wait_idle();

        // empty range, written mid-byte so the partial byte is dropped
        write_register(REG_LOW, 31'd1000);
        write_register(REG_HIGH, 31'h7FFF_FFFD);
        write_register(REG_MODE, 31'h7FFF_FFFF);
        @(negedge clk);
        queue_raw(10'h000);
        queue_raw(10'h3FF);
        queue_sample(1'b0);
        queue_sample(1'b1);
        wait_idle();

        // single-value range at the bottom
        write_register(REG_LOW, VAL_MIN);
        write_register(REG_HIGH, VAL_MIN + 1'b1);
        @(negedge clk);
        queue_sample(1'b1);
        queue_sample(1'b0);
        queue_sample(1'b1);
        wait_idle();

        // low equal to high at the top, then high at the very bottom
        write_register(REG_LOW, VAL_MAX);
        write_register(REG_HIGH, VAL_MAX);
        @(negedge clk);
        queue_sample(1'b0);
        queue_sample(1'b1);
        wait_idle();
        write_register(REG_HIGH, VAL_MIN);
        @(negedge clk);
        queue_sample(1'b1);
        queue_sample(1'b0);
        wait_idle();

        // two values: a one-bit field
        write_register(REG_LOW, 31'd5);
        write_register(REG_HIGH, 31'd7);
        @(negedge clk);
        realign_stages();
        queue_white_bit(1'b1);
        queue_white_bit(1'b0);
        wait_idle();

        // every sample makes a value; receiver holds off so the block backs up
        write_register(REG_LOW, 31'd7);
        write_register(REG_HIGH, 31'd7);
        @(negedge clk);
        set_pacing(0);
        hold_req = 1'b1;
        repeat (40) queue_sample(1'($urandom_range(1)));
        wait_idle();
        settings_seen += 6;

        // random settings and samples
        while (samples_queued < ITEM_TARGET || values_built < VALUE_TARGET)
        begin
            pick_setting();
            phase++;
            run_batch(phase);
        end

        $display("Covered %0d samples and %0d checked values over %0d register settings,",
                 samples_taken, values_checked, settings_seen);
        $display("all four modes, empty and single-value ranges and a long receiver hold-off.");
        if (fault_count == 0)
            $display("[von_neumann_random_ranger] OK");
        else
            $display("[von_neumann_random_ranger] ERROR");
        $finish;
    end

endmodule
